// ===== hw/rtl/top_latency_tracker_core_macros.svh =====
// Assertion helpers used by the tracker sequencer.
`ifndef TOP_LATENCY_TRACKER_CORE_MACROS_SVH
`define TOP_LATENCY_TRACKER_CORE_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define TLT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication built on the check above.
`define TLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`TLT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication built on the check above.
`define TLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	`TLT_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/tlt_pkg.sv =====
package tlt_pkg;

	// Width of the reported slot number.
	localparam int unsigned SLOT_W = 3;

	// Command codes.
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// One request item.
	typedef struct packed {
		logic              cmd;
		logic [SLOT_W-1:0] entry_index;
		logic [31:0]       sample_duration;
		logic [31:0]       sample_time;
	} req_t;

	// One response item.
	typedef struct packed {
		logic              read_valid;
		logic [31:0]       read_duration;
		logic [31:0]       read_time;
		logic              was_stored;
		logic [SLOT_W-1:0] stored_slot;
		logic [31:0]       max_duration;
		logic [31:0]       min_duration;
		logic [63:0]       duration_sum;
		logic [31:0]       sample_count;
	} rsp_t;

	// Payload of one table entry.
	typedef struct packed {
		logic [31:0] duration;
		logic [31:0] stamp;
	} entry_t;

	// Running statistics.
	typedef struct packed {
		logic [31:0] max_dur;
		logic [31:0] min_dur;
		logic [63:0] sum;
		logic [31:0] count;
	} stats_t;

	// Status handed from the sequencer to the top level.
	typedef struct packed {
		logic              finish;
		logic              record;
		logic              stored;
		logic              in_range;
		logic [SLOT_W-1:0] slot;
	} seq_status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_FINISH
	} state_t;

endpackage

// ===== hw/rtl/tlt_entry_mem.sv =====
module tlt_entry_mem
	import tlt_pkg::*;
#(
	parameter int unsigned TOP_ENTRIES = 8,
	localparam int unsigned IDX_W = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic             rd_vld,
	output entry_t           rd_entry,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_entry
);

	entry_t                 mem [TOP_ENTRIES];
	logic [TOP_ENTRIES-1:0] valid_q;
	entry_t                 rd_entry_q;
	logic                   rd_vld_q;

	// Valid bits clear at reset; an entry is marked once it is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// Entry storage with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	// An entry never written reads as all zero.
	assign rd_vld   = rd_vld_q;
	assign rd_entry = rd_vld_q ? rd_entry_q : '0;

endmodule

// ===== hw/rtl/tlt_stats.sv =====
module tlt_stats
	import tlt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  logic [31:0] dur,
	output stats_t      stats_nxt
);

	stats_t stats_q;

	// Values after the current sample; a minimum of zero counts as unset.
	always_comb begin
		stats_nxt = stats_q;
		if (upd) begin
			if (dur > stats_q.max_dur) begin
				stats_nxt.max_dur = dur;
			end
			if ((dur < stats_q.min_dur) || (stats_q.min_dur == 32'd0)) begin
				stats_nxt.min_dur = dur;
			end
			stats_nxt.sum   = stats_q.sum + {32'd0, dur};
			stats_nxt.count = stats_q.count + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q <= '0;
		end else if (upd) begin
			stats_q <= stats_nxt;
		end
	end

endmodule

// ===== hw/rtl/tlt_seq.sv =====
`include "top_latency_tracker_core_macros.svh"

module tlt_seq
	import tlt_pkg::*;
#(
	parameter int unsigned TOP_ENTRIES = 8,
	localparam int unsigned IDX_W = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	input  logic             out_free,
	input  logic             rd_vld,
	input  logic [31:0]      rd_dur,
	output logic             rd_en,
	output logic [IDX_W-1:0] rd_addr,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output req_t             item,
	output seq_status_t      stat
);

	localparam int unsigned CNT_W = $clog2(TOP_ENTRIES + 1);
	localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(TOP_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOP_ENTRIES - 1);

	state_t           state_q, state_d;
	req_t             item_q;
	logic [CNT_W-1:0] issue_q;
	logic             cmp_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic [31:0]      lowest_q;
	logic             found_q;
	logic [IDX_W-1:0] chosen_q;
	logic             accept;
	logic             issue_ok;
	logic             hit_empty;
	logic             hit_lower;
	logic             scan_end;
	logic             record;

	assign accept = req_valid && req_ready;
	assign record = (item_q.cmd == CMD_RECORD);

	// Shared compare unit: one entry of the table is judged per cycle.
	assign issue_ok  = (issue_q < N_CNT);
	assign hit_empty = cmp_q && !rd_vld;
	assign hit_lower = cmp_q && rd_vld && (rd_dur < lowest_q);
	assign scan_end  = cmp_q && (hit_empty || (cmp_idx_q == LAST_IDX));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req.cmd == CMD_READ) ? S_READ : S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_READ: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req_ready     = (state_q == S_IDLE);
		rd_en         = 1'b0;
		rd_addr       = issue_q[IDX_W-1:0];
		stat.finish   = 1'b0;
		case (state_q)
			S_SCAN: begin
				rd_en = issue_ok && !scan_end;
			end
			S_READ: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(item_q.entry_index);
			end
			S_FINISH: begin
				stat.finish = out_free;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
		stat.record   = record;
		stat.stored   = record && found_q;
		stat.in_range = (32'(item_q.entry_index) < 32'(TOP_ENTRIES));
		stat.slot     = (record && found_q) ? SLOT_W'(chosen_q) : '0;
		wr_en         = stat.finish && record && found_q;
		wr_addr       = chosen_q;
		item          = item_q;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_q <= '0;
			cmp_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				issue_q <= '0;
				cmp_q   <= 1'b0;
				found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				if (rd_en) begin
					issue_q <= issue_q + CNT_W'(1);
				end
				cmp_q   <= rd_en;
				found_q <= found_q || hit_empty || hit_lower;
			end
		end
	end

	// Item and scan payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= req;
			lowest_q <= req.sample_duration;
			chosen_q <= '0;
		end else if (state_q == S_SCAN) begin
			cmp_idx_q <= issue_q[IDX_W-1:0];
			if (hit_empty || hit_lower) begin
				chosen_q <= cmp_idx_q;
			end
			if (hit_lower) begin
				lowest_q <= rd_dur;
			end
		end
	end

	`TLT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, !req_ready, "ready right after an accepted item")
	`TLT_ASSERT_NXT(a_finish_to_idle, clk, arst_n, stat.finish, state_q == S_IDLE, "sequencer did not return to idle")
	`TLT_ASSERT_IMP(a_slot_in_table, clk, arst_n, wr_en, 32'(chosen_q) < 32'(TOP_ENTRIES), "write beyond the table")
	`TLT_ASSERT_IMP(a_lowest_bound, clk, arst_n, state_q == S_SCAN, lowest_q <= item_q.sample_duration, "scan minimum above the sample")

endmodule

// ===== hw/rtl/top_latency_tracker_core.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_t: cmd, entry_index, sample_duration, sample_time
// rsp       out        rsp_valid / rsp_ready  rsp_t: read fields, store result, statistics
//
// A record item scans the table one entry per cycle through a single compare unit and the
// one read port of the entry memory, stopping at the first empty entry or after the last
// entry when the table is full. A read item passes through the read and finish states.
// Reset clears the valid bits and statistics at once; there is no clearing pass.
// The result sits in an output register, so the next item is taken while it waits; a
// finished item holds in its last state only while that register is still occupied.
module top_latency_tracker_core
	import tlt_pkg::*;
#(
	parameter int unsigned TOP_ENTRIES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned IDX_W = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_vld;
	entry_t           rd_entry;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	req_t             item;
	seq_status_t      stat;
	stats_t           stats_nxt;
	logic             out_free;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;

	assign out_free = !rsp_valid_q || rsp_ready;

	tlt_seq #(
		.TOP_ENTRIES(TOP_ENTRIES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.out_free (out_free),
		.rd_vld   (rd_vld),
		.rd_dur   (rd_entry.duration),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.item     (item),
		.stat     (stat)
	);

	tlt_entry_mem #(
		.TOP_ENTRIES(TOP_ENTRIES)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_vld  (rd_vld),
		.rd_entry(rd_entry),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_entry({item.sample_duration, item.sample_time})
	);

	tlt_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (stat.finish && stat.record),
		.dur      (item.sample_duration),
		.stats_nxt(stats_nxt)
	);

	// Assemble the result item.
	always_comb begin
		rsp_d = '0;
		if (!stat.record && stat.in_range) begin
			rsp_d.read_valid    = rd_vld;
			rsp_d.read_duration = rd_entry.duration;
			rsp_d.read_time     = rd_entry.stamp;
		end
		rsp_d.was_stored   = stat.stored;
		rsp_d.stored_slot  = stat.slot;
		rsp_d.max_duration = stats_nxt.max_dur;
		rsp_d.min_duration = stats_nxt.min_dur;
		rsp_d.duration_sum = stats_nxt.sum;
		rsp_d.sample_count = stats_nxt.count;
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (stat.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/top_latency_tracker_core_tb.sv =====
`timescale 1ns / 1ps

module top_latency_tracker_core_tb;
	import tlt_pkg::*;

	localparam int unsigned TRACK_ENTRIES = 8;
	localparam int unsigned RANDOM_ITEMS = 1725;
	localparam int unsigned HOLD_AFTER_ITEMS = 700;
	localparam int unsigned HOLD_CYCLES = 500;
	localparam int unsigned DRAIN_CYCLES = 20;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		RX_FREE,
		RX_HALF,
		RX_QUARTER,
		RX_TRICKLE
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	top_latency_tracker_core #(
		.TOP_ENTRIES(TRACK_ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Shadow copy of the tracker table and its running statistics.
	logic        tbl_valid[TRACK_ENTRIES];
	logic [31:0] tbl_dur[TRACK_ENTRIES];
	logic [31:0] tbl_stamp[TRACK_ENTRIES];
	logic [31:0] stat_max;
	logic [31:0] stat_min;
	logic [63:0] stat_sum;
	logic [31:0] stat_count;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   error_count = 0;
	int   req_count = 0;
	bit   req_taken = 1'b0;

	// Sender burst state.
	int burst_left = 0;
	int gap_left = 0;

	// Receiver stall state.
	rx_mode_t rx_mode = RX_FREE;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	task automatic report_error(string what);
		$display("[%0t] ERROR: %s", $realtime, what);
		error_count++;
	endtask

	// Applies one item to the shadow state and returns the response it should produce.
	function automatic rsp_t predict_tracker_rsp(req_t item);
		rsp_t        r;
		int          chosen;
		logic        found;
		logic [31:0] lowest;
		r = '0;
		if (item.cmd == CMD_RECORD) begin
			lowest = item.sample_duration;
			chosen = 0;
			found = 1'b0;
			// First empty entry wins; otherwise the strictly smallest entry below the sample.
			for (int k = 0; k < TRACK_ENTRIES; k++) begin
				if (!tbl_valid[k]) begin
					chosen = k;
					found = 1'b1;
					break;
				end
				if (tbl_dur[k] < lowest) begin
					lowest = tbl_dur[k];
					chosen = k;
					found = 1'b1;
				end
			end
			if (found) begin
				tbl_valid[chosen] = 1'b1;
				tbl_dur[chosen] = item.sample_duration;
				tbl_stamp[chosen] = item.sample_time;
				r.was_stored = 1'b1;
				r.stored_slot = chosen[SLOT_W-1:0];
			end
			if (item.sample_duration > stat_max)
				stat_max = item.sample_duration;
			// A minimum of zero means unset, so any sample replaces it.
			if (item.sample_duration < stat_min || stat_min == 0)
				stat_min = item.sample_duration;
			stat_sum = stat_sum + 64'(item.sample_duration);
			stat_count = stat_count + 32'd1;
		end else if (item.entry_index < TRACK_ENTRIES) begin
			r.read_valid = tbl_valid[item.entry_index];
			r.read_duration = tbl_dur[item.entry_index];
			r.read_time = tbl_stamp[item.entry_index];
		end
		r.max_duration = stat_max;
		r.min_duration = stat_min;
		r.duration_sum = stat_sum;
		r.sample_count = stat_count;
		return r;
	endfunction

	task automatic queue_record(logic [31:0] dur, logic [31:0] stamp);
		req_t item;
		item.cmd = CMD_RECORD;
		item.entry_index = SLOT_W'($urandom_range(0, 7));
		item.sample_duration = dur;
		item.sample_time = stamp;
		pending_reqs.push_back(item);
	endtask

	task automatic queue_read(logic [SLOT_W-1:0] idx);
		req_t item;
		item.cmd = CMD_READ;
		item.entry_index = idx;
		item.sample_duration = $urandom();
		item.sample_time = $urandom();
		pending_reqs.push_back(item);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Sender: bursts of items separated by idle gaps, valid held until accepted.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (gap_left != 0) begin
				req_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off once, so the block fills and pushes back on its input.
	always @(negedge clk) begin
		if (!hold_done && req_count >= HOLD_AFTER_ITEMS) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: switches between stall patterns at random intervals.
	always @(negedge clk) begin
		logic take;
		if (arst_n) begin
			if (mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(32, 128);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_FREE:    take = 1'b1;
				RX_HALF:    take = $urandom_range(0, 1) == 0;
				RX_QUARTER: take = $urandom_range(0, 3) == 0;
				default:    take = $urandom_range(0, 9) == 0;
			endcase
			rsp_ready <= (hold_left == 0) && take;
		end
	end

	// Monitor: checks responses against the oldest expectation, then predicts new items.
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			req_taken = 1'b0;
		end else begin
			req_taken = req_valid && req_ready;
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					report_error($sformatf("response %p with nothing expected", rsp));
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.read_valid !== want.read_valid)
						report_error($sformatf("read_valid %0h, expected %0h",
							rsp.read_valid, want.read_valid));
					if (rsp.read_duration !== want.read_duration)
						report_error($sformatf("read_duration %0h, expected %0h",
							rsp.read_duration, want.read_duration));
					if (rsp.read_time !== want.read_time)
						report_error($sformatf("read_time %0h, expected %0h",
							rsp.read_time, want.read_time));
					if (rsp.was_stored !== want.was_stored)
						report_error($sformatf("was_stored %0h, expected %0h",
							rsp.was_stored, want.was_stored));
					if (rsp.stored_slot !== want.stored_slot)
						report_error($sformatf("stored_slot %0h, expected %0h",
							rsp.stored_slot, want.stored_slot));
					if (rsp.max_duration !== want.max_duration)
						report_error($sformatf("max_duration %0h, expected %0h",
							rsp.max_duration, want.max_duration));
					if (rsp.min_duration !== want.min_duration)
						report_error($sformatf("min_duration %0h, expected %0h",
							rsp.min_duration, want.min_duration));
					if (rsp.duration_sum !== want.duration_sum)
						report_error($sformatf("duration_sum %0h, expected %0h",
							rsp.duration_sum, want.duration_sum));
					if (rsp.sample_count !== want.sample_count)
						report_error($sformatf("sample_count %0h, expected %0h",
							rsp.sample_count, want.sample_count));
				end
			end
			if (req_valid && req_ready) begin
				expected_rsps.push_back(predict_tracker_rsp(req));
				req_count++;
			end
		end
	end

	initial begin
		logic [31:0] level;
		int          pick;
		for (int k = 0; k < TRACK_ENTRIES; k++) begin
			tbl_valid[k] = 1'b0;
			tbl_dur[k] = '0;
			tbl_stamp[k] = '0;
		end
		stat_max = '0;
		stat_min = '0;
		stat_sum = '0;
		stat_count = '0;

		// Reads of the empty table right after reset.
		queue_read(3'd0);
		queue_read(3'd7);
		// Zero sample leaves the minimum unset, then the largest possible duration.
		queue_record(32'd0, 32'hFFFF_FFFF);
		queue_record(32'hFFFF_FFFF, 32'd0);
		// Fill the rest of the table, with a duplicate duration.
		queue_record(32'd5, 32'h1111_1111);
		queue_record(32'd5, 32'h2222_2222);
		queue_record(32'd7, 32'h3333_3333);
		queue_record(32'd3, 32'h4444_4444);
		queue_record(32'd100, 32'h5555_5555);
		queue_record(32'd2, 32'h6666_6666);
		// Full table: replace the zero entry, then a sample below everything.
		queue_record(32'd1, 32'hAAAA_AAAA);
		queue_record(32'd0, 32'h5A5A_5A5A);
		queue_record(32'd2, 32'hA5A5_A5A5);
		// Equal to the smallest entry is not stored; ties go to the lowest index.
		queue_record(32'd2, 32'h0F0F_0F0F);
		queue_record(32'd4, 32'hF0F0_F0F0);
		for (int k = 0; k < TRACK_ENTRIES; k++)
			queue_read(SLOT_W'(k));

		// Random part: durations mostly follow a rising level so the table keeps turning over.
		level = 32'd8;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 9) < 3) begin
				queue_read(SLOT_W'($urandom_range(0, 7)));
			end else begin
				if ($urandom_range(0, 1) == 0 && level < 32'hFF00_0000)
					level = level + $urandom_range(0, 1 << 23);
				pick = $urandom_range(0, 99);
				if (pick < 70)
					queue_record(level + $urandom_range(0, 3), $urandom());
				else if (pick < 90)
					queue_record($urandom_range(0, 15), $urandom());
				else
					queue_record($urandom(), $urandom());
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every item to be taken and answered, then let the block settle.
		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_rsps.size() != 0)
			report_error($sformatf("%0d responses never arrived", expected_rsps.size()));

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tlt_pkg.sv
hw/rtl/tlt_entry_mem.sv
hw/rtl/tlt_stats.sv
hw/rtl/tlt_seq.sv
hw/rtl/top_latency_tracker_core.sv
tb/top_latency_tracker_core_tb.sv
